// ===== sv/ipv4_header_parser_core_assert.svh =====
// ---------------------------------------------------------------------------
// IPv4 header parser assertion macros
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSER_CORE_ASSERT_SVH
`define IPV4_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define IHP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ihp_pkg.sv =====
// ---------------------------------------------------------------------------
// IPv4 header parser package
// Status codes, option numbers, walk phases and header constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ihp_pkg;

	localparam int unsigned FIXED_HDR_BYTES = 20;
	localparam logic [3:0]  IP_VERSION      = 4'd4;
	localparam logic [3:0]  MIN_IHL         = 4'd5;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT_FIXED = 3'd1,
		ST_VERSION     = 3'd2,
		ST_SHORT_HDR   = 3'd3,
		ST_IHL_LOW     = 3'd4,
		ST_OPTION      = 3'd5,
		ST_TOTAL_LOW   = 3'd6,
		ST_TOTAL_HIGH  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} opt_phase_t;

	localparam logic [4:0] OPT_END      = 5'd0;
	localparam logic [4:0] OPT_NOP      = 5'd1;
	localparam logic [4:0] OPT_SECURITY = 5'd2;
	localparam logic [4:0] OPT_LSRR     = 5'd3;
	localparam logic [4:0] OPT_TSTAMP   = 5'd4;
	localparam logic [4:0] OPT_RR       = 5'd7;
	localparam logic [4:0] OPT_STREAM   = 5'd8;
	localparam logic [4:0] OPT_SSRR     = 5'd9;
	localparam logic [4:0] OPT_RTR_ALRT = 5'd20;

	localparam logic [7:0] LEN_SECURITY  = 8'd11;
	localparam logic [7:0] LEN_ROUTE_MIN = 8'd7;
	localparam logic [7:0] LEN_TS_MIN    = 8'd8;
	localparam logic [7:0] LEN_TS_ADDR   = 8'd12;
	localparam logic [7:0] LEN_FIXED4    = 8'd4;
	localparam logic [3:0] TS_FLG_ADDR   = 4'd1;
	localparam logic [3:0] TS_FLG_PRESP  = 4'd3;

endpackage

`default_nettype wire

// ===== sv/ihp_byte_if.sv =====
// ---------------------------------------------------------------------------
// IPv4 header parser byte channel
// One packet byte per request, last marks the final byte.
// ---------------------------------------------------------------------------
`default_nettype none

interface ihp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/ihp_result_if.sv =====
// ---------------------------------------------------------------------------
// IPv4 header parser result channel
// One status and header field set per packet.
// ---------------------------------------------------------------------------
`default_nettype none

interface ihp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  ihl_bytes;
	logic [15:0] total_length;
	logic [7:0]  service_byte;
	logic [15:0] identification;
	logic [2:0]  frag_flags;
	logic [12:0] fragment_offset;
	logic [7:0]  time_to_live;
	logic [7:0]  protocol_number;
	logic [15:0] header_checksum;
	logic [31:0] source_address;
	logic [31:0] destination_address;

	modport source (
		output valid, output status, output ihl_bytes, output total_length,
		output service_byte, output identification, output frag_flags,
		output fragment_offset, output time_to_live, output protocol_number,
		output header_checksum, output source_address, output destination_address,
		input ready
	);
	modport sink (
		input valid, input status, input ihl_bytes, input total_length,
		input service_byte, input identification, input frag_flags,
		input fragment_offset, input time_to_live, input protocol_number,
		input header_checksum, input source_address, input destination_address,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/ipv4_header_parser_core.sv =====
// ---------------------------------------------------------------------------
// IPv4 header parser core
// Captures the fixed header, walks and checks options, reports one status
// and the header fields per packet; fields are zero unless status is OK.
// ---------------------------------------------------------------------------
//  channel | dir | request                  | handshake
//  pkt     | in  | data_byte, last          | valid/ready
//  hdr     | out | status + header fields   | valid/ready
//
//  One byte per cycle while pkt.ready is high; each byte updates the counter
//  and, as applies, the header store or option walker in the cycle taken.
//  The result is valid in the cycle after the last byte is taken.
//  pkt.ready drops only while a result waits and hdr.ready is low.
//  Reset clears the byte counter, walk phase, fault/end flags and result valid.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ipv4_header_parser_core_assert.svh"

module ipv4_header_parser_core
	import ihp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	ihp_byte_if.sink     pkt,
	ihp_result_if.source hdr
);

	logic [15:0] count_q, count_d;
	logic [7:0]  hdr_q [FIXED_HDR_BYTES];
	logic [7:0]  hdr_d [FIXED_HDR_BYTES];
	opt_phase_t  phase_q, phase_d;
	logic [4:0]  kind_q, kind_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  left_q, left_d;
	logic        fault_q, fault_d;
	logic        ended_q, ended_d;

	logic        res_valid_q;
	status_t     status_q;
	logic [5:0]  hlen_q;
	logic [15:0] tlen_q, ident_q, csum_q;
	logic [7:0]  tos_q, ttl_q, proto_q;
	logic [2:0]  flags_q;
	logic [12:0] frag_q;
	logic [31:0] saddr_q, daddr_q;

	logic        accept;
	logic        walk;
	logic [5:0]  hl_cur, rem, rem1, hl_new;
	logic [15:0] tlen_new;
	status_t     status_d;
	logic        ok;

	function automatic logic len_ok(logic [4:0] kind, logic [7:0] len, logic [5:0] r);
		logic [7:0] r8;
		logic       fits;
		logic       res;
		r8   = {2'b00, r};
		fits = r8 >= (len - 8'd2);
		if (len < 8'd2) begin
			res = 1'b0;
		end else if (kind == OPT_SECURITY) begin
			res = (len == LEN_SECURITY) && (r8 >= LEN_SECURITY - 8'd2);
		end else if (kind == OPT_LSRR || kind == OPT_RR || kind == OPT_SSRR) begin
			res = (len >= LEN_ROUTE_MIN) && (len[1:0] == 2'b11) && fits;
		end else if (kind == OPT_TSTAMP) begin
			res = (len >= LEN_TS_MIN) && (len[1:0] == 2'b00) && fits;
		end else if (kind == OPT_STREAM || kind == OPT_RTR_ALRT) begin
			res = (len == LEN_FIXED4) && (r8 >= LEN_FIXED4 - 8'd2);
		end else begin
			res = fits;
		end
		return res;
	endfunction

	assign pkt.ready = !res_valid_q || hdr.ready;
	assign accept    = pkt.valid && pkt.ready;

	assign hl_cur = {hdr_q[0][3:0], 2'b00};
	assign rem    = hl_cur - count_q[5:0];
	assign rem1   = rem - 6'd1;
	assign walk   = (count_q >= 16'(FIXED_HDR_BYTES)) && (count_q < {10'd0, hl_cur})
		&& !fault_q && !ended_q;

	always_comb begin
		hdr_d   = hdr_q;
		phase_d = phase_q;
		kind_d  = kind_q;
		len_d   = len_q;
		left_d  = left_q;
		fault_d = fault_q;
		ended_d = ended_q;
		count_d = (count_q != 16'hffff) ? count_q + 16'd1 : count_q;
		if (count_q < 16'(FIXED_HDR_BYTES)) begin
			hdr_d[count_q[4:0]] = pkt.data_byte;
		end
		if (walk) begin
			unique case (phase_q)
				PH_TYPE: begin
					kind_d = pkt.data_byte[4:0];
					if (pkt.data_byte[4:0] == OPT_END) begin
						ended_d = 1'b1;
					end else if (pkt.data_byte[4:0] == OPT_NOP) begin
						phase_d = PH_TYPE;
					end else if (rem < 6'd2) begin
						fault_d = 1'b1;
					end else begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					len_d = pkt.data_byte;
					if (!len_ok(kind_q, pkt.data_byte, rem1)) begin
						fault_d = 1'b1;
					end else begin
						left_d  = pkt.data_byte - 8'd2;
						phase_d = (pkt.data_byte != 8'd2) ? PH_BODY : PH_TYPE;
					end
				end
				PH_BODY: begin
					if (kind_q == OPT_TSTAMP && left_q == len_q - 8'd3
						&& (pkt.data_byte[3:0] == TS_FLG_ADDR
						|| pkt.data_byte[3:0] == TS_FLG_PRESP)
						&& len_q < LEN_TS_ADDR) begin
						fault_d = 1'b1;
					end
					left_d = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase
		end
	end

	assign hl_new   = {hdr_d[0][3:0], 2'b00};
	assign tlen_new = {hdr_d[2], hdr_d[3]};

	always_comb begin
		priority if (count_d < 16'(FIXED_HDR_BYTES)) begin
			status_d = ST_SHORT_FIXED;
		end else if (hdr_d[0][7:4] != IP_VERSION) begin
			status_d = ST_VERSION;
		end else if (count_d < {10'd0, hl_new}) begin
			status_d = ST_SHORT_HDR;
		end else if (hdr_d[0][3:0] < MIN_IHL) begin
			status_d = ST_IHL_LOW;
		end else if (fault_d) begin
			status_d = ST_OPTION;
		end else if (tlen_new < {10'd0, hl_new}) begin
			status_d = ST_TOTAL_LOW;
		end else if (tlen_new > count_d) begin
			status_d = ST_TOTAL_HIGH;
		end else begin
			status_d = ST_OK;
		end
	end

	assign ok = (status_d == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			phase_q     <= PH_TYPE;
			fault_q     <= 1'b0;
			ended_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (pkt.last) begin
					count_q <= '0;
					phase_q <= PH_TYPE;
					fault_q <= 1'b0;
					ended_q <= 1'b0;
				end else begin
					count_q <= count_d;
					phase_q <= phase_d;
					fault_q <= fault_d;
					ended_q <= ended_d;
				end
			end
			if (accept && pkt.last) begin
				res_valid_q <= 1'b1;
			end else if (hdr.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q  <= hdr_d;
			kind_q <= kind_d;
			len_q  <= len_d;
			left_q <= left_d;
		end
		if (accept && pkt.last) begin
			status_q <= status_d;
			hlen_q   <= ok ? hl_new : '0;
			tlen_q   <= ok ? tlen_new : '0;
			tos_q    <= ok ? hdr_d[1] : '0;
			ident_q  <= ok ? {hdr_d[4], hdr_d[5]} : '0;
			flags_q  <= ok ? hdr_d[6][7:5] : '0;
			frag_q   <= ok ? {hdr_d[6][4:0], hdr_d[7]} : '0;
			ttl_q    <= ok ? hdr_d[8] : '0;
			proto_q  <= ok ? hdr_d[9] : '0;
			csum_q   <= ok ? {hdr_d[10], hdr_d[11]} : '0;
			saddr_q  <= ok ? {hdr_d[12], hdr_d[13], hdr_d[14], hdr_d[15]} : '0;
			daddr_q  <= ok ? {hdr_d[16], hdr_d[17], hdr_d[18], hdr_d[19]} : '0;
		end
	end

	assign hdr.valid               = res_valid_q;
	assign hdr.status              = status_q;
	assign hdr.ihl_bytes           = hlen_q;
	assign hdr.total_length        = tlen_q;
	assign hdr.service_byte        = tos_q;
	assign hdr.identification      = ident_q;
	assign hdr.frag_flags          = flags_q;
	assign hdr.fragment_offset     = frag_q;
	assign hdr.time_to_live        = ttl_q;
	assign hdr.protocol_number     = proto_q;
	assign hdr.header_checksum     = csum_q;
	assign hdr.source_address      = saddr_q;
	assign hdr.destination_address = daddr_q;

	`IHP_ASSERT_NEXT(a_last_gives_result, accept && pkt.last, hdr.valid, "no result after last byte")
	`IHP_ASSERT_NEXT(a_last_clears_count, accept && pkt.last, count_q == '0, "count not cleared")
	`IHP_ASSERT_NOW(a_end_only_in_type, ended_q, phase_q == PH_TYPE, "END seen mid option")
	`IHP_ASSERT_NOW(a_err_fields_zero, hdr.valid && hdr.status != ST_OK, hdr.ihl_bytes == '0 && hdr.source_address == '0 && hdr.total_length == '0, "fields set on error")
	`IHP_ASSERT_NOW(a_ok_min_header, hdr.valid && hdr.status == ST_OK, hdr.ihl_bytes >= 6'd20 && hdr.total_length >= 16'd20, "ok with short header")

endmodule

`default_nettype wire
